FILE: hw/rtl/acw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acw_pkg: shared definitions of the adaptive credit window
// Operation and status codes, field widths, stream packing offsets and the
// structs passed between the configuration, engine and top-level modules.
// ----------------------------------------------------------------------------
package acw_pkg;

  // Default sizes of the internal counters and the window register
  localparam int COUNT_WIDTH_DEF  = 48;
  localparam int WINDOW_WIDTH_DEF = 40;

  // Fixed field widths on the ports
  localparam int OP_W      = 2;
  localparam int LEN_W     = 32;
  localparam int TOTAL_W   = 48;
  localparam int BACKLOG_W = 48;
  localparam int STATUS_W  = 2;
  localparam int WINF_W    = 40;
  localparam int DELTA_W   = 49;
  localparam int LIMIT_W   = 48;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 48;

  // Operation codes
  localparam logic [OP_W-1:0] OP_START    = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND   = 2'd1;
  localparam logic [OP_W-1:0] OP_FEEDBACK = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_STALE   = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_WINDOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_WINDOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BACKLOG_LIMIT = 2'd2;

  localparam logic [WINF_W-1:0] MAX_WINDOW_RST = 40'd2097152;

  // Request payload packing (lowest bit first)
  localparam int ID_LEN_LSB     = 0;
  localparam int ID_OK_BIT      = ID_LEN_LSB + LEN_W;
  localparam int ID_TOTAL_LSB   = ID_OK_BIT + 1;
  localparam int ID_BACKLOG_LSB = ID_TOTAL_LSB + TOTAL_W;
  localparam int IN_BITS        = ID_BACKLOG_LSB + BACKLOG_W;
  localparam int IN_DATA_W      = ((IN_BITS + 7) / 8) * 8;

  // Result payload packing (lowest bit first)
  localparam int OD_WRITABLE_BIT = 0;
  localparam int OD_WAKE_BIT     = 1;
  localparam int OD_WIN_LSB      = 2;
  localparam int OD_DELTA_LSB    = OD_WIN_LSB + WINF_W;
  localparam int OUT_BITS        = OD_DELTA_LSB + DELTA_W;
  localparam int OUT_DATA_W      = ((OUT_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic [WINF_W-1:0]  max_window;
    logic [WINF_W-1:0]  min_window;
    logic [LIMIT_W-1:0] backlog_limit;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [LEN_W-1:0]     append_length;
    logic                 sink_ok;
    logic [TOTAL_W-1:0]   consumed_total;
    logic [BACKLOG_W-1:0] socket_backlog;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                writable;
    logic                wake_waiters;
    logic [WINF_W-1:0]   window_now;
    logic [DELTA_W-1:0]  socket_delta;
  } result_t;

endpackage

FILE: hw/rtl/acw_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acw_cfg_regs: configuration registers
// Holds max window, min window and socket backlog limit; takes one write a
// cycle, writes to an unused index are dropped.
// ----------------------------------------------------------------------------
module acw_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [acw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [acw_pkg::CFG_DAT_W-1:0]  cfg_data_i,
  output acw_pkg::cfg_t                  cfg_o
);

  localparam int WinW = acw_pkg::WINF_W;
  localparam int LimW = acw_pkg::LIMIT_W;

  acw_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        acw_pkg::REG_MAX_WINDOW:    cfg_d.max_window    = WinW'(cfg_data_i);
        acw_pkg::REG_MIN_WINDOW:    cfg_d.min_window    = WinW'(cfg_data_i);
        acw_pkg::REG_BACKLOG_LIMIT: cfg_d.backlog_limit = LimW'(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_window    <= acw_pkg::MAX_WINDOW_RST;
      cfg_q.min_window    <= '0;
      cfg_q.backlog_limit <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/acw_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acw_engine: window state and combinational step logic
// Holds produced and consumed counts and the window; computes the result of
// the registered request and updates the state when the request advances.
// ----------------------------------------------------------------------------
module acw_engine #(
  parameter int COUNT_WIDTH  = acw_pkg::COUNT_WIDTH_DEF,
  parameter int WINDOW_WIDTH = acw_pkg::WINDOW_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  acw_pkg::item_t   item_i,
  input  acw_pkg::cfg_t    cfg_i,
  output acw_pkg::result_t result_o
);

  localparam int CW  = COUNT_WIDTH;
  localparam int WW  = WINDOW_WIDTH;
  localparam int LW  = (CW > WW) ? CW : WW;
  localparam int SW  = (WW + 1 > acw_pkg::WINF_W) ? WW + 1 : acw_pkg::WINF_W;
  localparam int DW  = acw_pkg::DELTA_W;
  localparam int NW  = (CW > DW) ? CW : DW;
  localparam int OWW = acw_pkg::WINF_W;

  logic [CW-1:0] prod_q, prod_d;
  logic [CW-1:0] cons_q, cons_d;
  logic [WW-1:0] win_q, win_d;

  logic [CW-1:0]  total;
  logic [CW-1:0]  adv;
  logic [NW-1:0]  adv_x;
  logic [NW-1:0]  adv_neg;
  logic [OWW-1:0] eff_min;
  logic           limit_on;
  logic           full_now;
  logic [WW:0]    dbl_raw;
  logic [SW-1:0]  dbl;
  logic [SW-1:0]  max_x;
  logic           can_grow;
  logic [WW-1:0]  grown;

  logic [acw_pkg::STATUS_W-1:0] status;
  logic                         wake;
  logic [DW-1:0]                delta;
  logic                         writable;

  function automatic logic is_full(logic [CW-1:0] p, logic [CW-1:0] c, logic [WW-1:0] w);
    logic [CW-1:0] d0;
    logic [LW-1:0] diff;
    d0   = p - c;
    diff = LW'(d0);
    return (p >= c) && (diff >= LW'(w));
  endfunction

  function automatic logic [WW-1:0] win_sat(logic [SW-1:0] v);
    if (v > SW'({WW{1'b1}})) begin
      return {WW{1'b1}};
    end
    return WW'(v);
  endfunction

  function automatic logic BACKLOG_GT(logic [acw_pkg::BACKLOG_W-1:0] b,
                                      logic [acw_pkg::LIMIT_W-1:0] l);
    return b > l;
  endfunction

  assign total    = CW'(item_i.consumed_total);
  assign adv      = total - cons_q;
  assign adv_x    = NW'(adv);
  assign adv_neg  = '0 - adv_x;
  assign limit_on = (cfg_i.backlog_limit != '0);
  assign eff_min  = (cfg_i.max_window != '0 && cfg_i.min_window > cfg_i.max_window) ?
                    '0 : cfg_i.min_window;
  assign full_now = is_full(prod_q, cons_q, win_q);

  // Doubling, clamped to max window and saturated at the register width
  assign dbl_raw  = {win_q, 1'b0};
  assign max_x    = SW'(cfg_i.max_window);
  assign can_grow = (cfg_i.max_window == '0) || (SW'(win_q) < max_x);
  always_comb begin
    dbl = SW'(dbl_raw);
    if (cfg_i.max_window != '0 && dbl > max_x) begin
      dbl = max_x;
    end
    grown = win_sat(dbl);
  end

  always_comb begin
    prod_d = prod_q;
    cons_d = cons_q;
    win_d  = win_q;
    status = acw_pkg::ST_OK;
    wake   = 1'b0;
    delta  = '0;
    case (item_i.op)
      acw_pkg::OP_START: begin
        prod_d = '0;
        cons_d = '0;
        if (limit_on && eff_min != '0) begin
          win_d = win_sat(SW'(eff_min));
        end else begin
          win_d = win_sat(SW'(cfg_i.max_window));
        end
      end
      acw_pkg::OP_APPEND: begin
        // a refused write leaves the count as it was, so no add is needed
        if (win_q != '0 && full_now) begin
          status = acw_pkg::ST_FULL;
        end else if (!item_i.sink_ok) begin
          status = acw_pkg::ST_REFUSED;
        end else begin
          if (win_q != '0) begin
            prod_d = prod_q + CW'(item_i.append_length);
          end
          if (limit_on) begin
            delta = DW'(item_i.append_length);
          end
        end
      end
      acw_pkg::OP_FEEDBACK: begin
        if (win_q == '0) begin
          status = acw_pkg::ST_OK;
        end else if (total <= cons_q) begin
          status = acw_pkg::ST_STALE;
        end else begin
          if (limit_on) begin
            delta = adv_neg[DW-1:0];
            if (BACKLOG_GT(item_i.socket_backlog, cfg_i.backlog_limit)) begin
              if (eff_min != '0) begin
                win_d = win_sat(SW'(eff_min));
              end else begin
                win_d = win_q >> 1;
              end
            end else if (is_full(prod_q, total, win_q) && can_grow) begin
              win_d = grown;
            end
          end
          cons_d = total;
          wake   = full_now && !is_full(prod_q, total, win_d);
        end
      end
      default: ;
    endcase
    writable = (win_d == '0) || !is_full(prod_d, cons_d, win_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
      cons_q <= '0;
      win_q  <= '0;
    end else if (advance_i) begin
      prod_q <= prod_d;
      cons_q <= cons_d;
      win_q  <= win_d;
    end
  end

  assign result_o.status       = status;
  assign result_o.writable     = writable;
  assign result_o.wake_waiters = wake;
  assign result_o.window_now   = OWW'(win_d);
  assign result_o.socket_delta = delta;

endmodule

FILE: hw/rtl/adaptive_credit_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_credit_window: sender-side credit window for one stream
// Top level: request and result registers around the window engine, plus
// the configuration register file.
// ----------------------------------------------------------------------------
// Usage
//   s_axis carries requests: tuser holds the operation (start, append,
//   feedback), tdata the length, sink flag, consumed total and backlog.
//   m_axis returns one result per request: tuser holds the status, tdata
//   the writable and wake flags, the current window and the socket delta.
//   The cfg channel writes max window, min window and backlog limit by
//   index; it is always ready and should only be used while idle.
// Timing
//   A request is registered on acceptance; it advances when the output
//   register is free or emptying, and its result then lands in the output
//   register, raising tvalid. The state update and the result share one
//   pass of logic, so one request a cycle is taken back to back unless m_axis stalls.
// Reset and stall
//   Reset clears both counters and the window (no flow control until a
//   start) and loads the default configuration. If m_axis stalls, the
//   result holds and one more request waits in the input register; then
//   s_axis_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module adaptive_credit_window #(
  parameter int COUNT_WIDTH  = acw_pkg::COUNT_WIDTH_DEF,
  parameter int WINDOW_WIDTH = acw_pkg::WINDOW_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // append_length[31:0], sink_ok[32], consumed_total[80:33],
  // socket_backlog[128:81], zero fill above
  input  logic [acw_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // op[1:0]
  input  logic [acw_pkg::OP_W-1:0]        s_axis_tuser,
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // writable[0], wake_waiters[1], window_now[41:2], socket_delta[90:42],
  // zero fill above
  output logic [acw_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // status[1:0]
  output logic [acw_pkg::STATUS_W-1:0]    m_axis_tuser,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [acw_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [acw_pkg::CFG_DAT_W-1:0]   cfg_data_i
);

  localparam int FillW = acw_pkg::OUT_DATA_W - acw_pkg::OUT_BITS;

  acw_pkg::cfg_t    cfg;
  acw_pkg::item_t   item_q, item_d;
  acw_pkg::result_t res_comb;
  acw_pkg::result_t res_q;

  logic in_valid_q, in_valid_d;
  logic out_valid_q, out_valid_d;
  logic take_req;
  logic advance;

  // Advance the held request when the result register is free or emptying
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign take_req      = s_axis_tvalid && s_axis_tready;

  // Unpack the request fields
  always_comb begin
    item_d.op             = s_axis_tuser;
    item_d.append_length  = s_axis_tdata[acw_pkg::ID_LEN_LSB +: acw_pkg::LEN_W];
    item_d.sink_ok        = s_axis_tdata[acw_pkg::ID_OK_BIT];
    item_d.consumed_total = s_axis_tdata[acw_pkg::ID_TOTAL_LSB +: acw_pkg::TOTAL_W];
    item_d.socket_backlog = s_axis_tdata[acw_pkg::ID_BACKLOG_LSB +: acw_pkg::BACKLOG_W];
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (take_req) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: capture on accept, hold otherwise
  always_ff @(posedge clk_i) begin
    if (take_req) begin
      item_q <= item_d;
    end
    if (advance) begin
      res_q <= res_comb;
    end
  end

  acw_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  acw_engine #(
    .COUNT_WIDTH  (COUNT_WIDTH),
    .WINDOW_WIDTH (WINDOW_WIDTH)
  ) u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item_q),
    .cfg_i     (cfg),
    .result_o  (res_comb)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.status;
  assign m_axis_tdata  = {{FillW{1'b0}}, res_q.socket_delta, res_q.window_now,
                          res_q.wake_waiters, res_q.writable};

endmodule

FILE: hw/rtl/acw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acw_checker: port-level checks of the adaptive credit window
// Watches the result stream for held results and consistent status flags.
// ----------------------------------------------------------------------------
module acw_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [acw_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input logic [acw_pkg::STATUS_W-1:0]    m_axis_tuser
);

  logic        writable;
  logic        wake;
  logic [acw_pkg::DELTA_W-1:0] delta;

  assign writable = m_axis_tdata[acw_pkg::OD_WRITABLE_BIT];
  assign wake     = m_axis_tdata[acw_pkg::OD_WAKE_BIT];
  assign delta    = m_axis_tdata[acw_pkg::OD_DELTA_LSB +: acw_pkg::DELTA_W];

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // A full refusal leaves the stream full
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == acw_pkg::ST_FULL |-> !writable && !wake
      && delta == '0)
    else $error("full status with writable window or side effect");

  // Waking waiters means the window has reopened after valid feedback
  a_wake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && wake |-> writable && m_axis_tuser == acw_pkg::ST_OK)
    else $error("wake without an open window");

  // Stale or refused requests move no socket bytes
  a_nodelta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == acw_pkg::ST_STALE ||
      m_axis_tuser == acw_pkg::ST_REFUSED) |-> delta == '0 && !wake)
    else $error("socket delta on stale or refused request");

endmodule

bind adaptive_credit_window acw_checker u_acw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
